>>> src/serial_frame_crc8_receiver_core_assert.svh
// Assertion macros for the serial frame receiver core.
`ifndef SERIAL_FRAME_CRC8_RECEIVER_CORE_ASSERT_SVH
`define SERIAL_FRAME_CRC8_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset.
`define SFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define SFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sfcrc8_pkg.sv
// Shared constants, codes and the CRC-8 byte update for the frame receiver.
`timescale 1ns / 1ps

package sfcrc8_pkg;

  localparam int CAPTURED_BYTES_DEF = 5;
  localparam int OUT_FIELDS         = 5;
  localparam int CFG_IDX_W          = 2;

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_LF  = 8'h0A;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_HDR = 2'd1;
  localparam status_t ST_CRC = 2'd2;

  typedef logic [2:0] phase_t;
  localparam phase_t PH_HDR1 = 3'd0;
  localparam phase_t PH_HDR2 = 3'd1;
  localparam phase_t PH_LEN  = 3'd2;
  localparam phase_t PH_DATA = 3'd3;
  localparam phase_t PH_CRC  = 3'd4;
  localparam phase_t PH_SKIP = 3'd5;

  // Reflected CRC-8, one byte in, LSB first.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/serial_frame_crc8_receiver_core.sv
// Top level: length-prefixed serial frame parser with CRC-8 check.
`timescale 1ns / 1ps

// Takes one received byte per word and parses frames of two header bytes,
// a length byte, the payload and a reflected CRC-8 (poly 0x8C, init 0) over
// header, length and payload. Each frame gives one result word: a status
// (ok, header mismatch, CRC mismatch) and the first five payload bytes,
// zero where the frame was short or the status is not ok. A header mismatch
// is reported on the offending header byte. After every result, bytes are
// dropped until CR LF has been seen. Each byte is parsed in the cycle it
// is accepted and its result lands in the output register, so a byte can
// be taken every cycle while no result waits or the waiting one is taken
// in that cycle. The user must write header values through cfg_* only
// while the block is idle; the block itself does not enforce this.
module serial_frame_crc8_receiver_core #(
  parameter int CAPTURED_BYTES = sfcrc8_pkg::CAPTURED_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sfcrc8_pkg::status_t              out_frame_status,
  output logic [7:0]                       out_controller_state,
  output logic [7:0]                       out_object_state,
  output logic [7:0]                       out_color_one,
  output logic [7:0]                       out_color_two,
  output logic [7:0]                       out_color_three,
  input  logic                             cfg_we,
  input  logic [sfcrc8_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_wdata
);
  import sfcrc8_pkg::*;

`include "serial_frame_crc8_receiver_core_assert.svh"

  localparam int IDX_W  = $clog2(CAPTURED_BYTES + 1);
  localparam int CAP_AW = (CAPTURED_BYTES > 1) ? $clog2(CAPTURED_BYTES) : 1;

  logic [7:0]       hdr1_r, hdr2_r;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             last_cr_r, last_cr_nxt;
  logic [7:0]       cap_r [CAPTURED_BYTES];

  logic             acc;
  logic             emit;
  status_t          emit_status;
  logic [7:0]       crc_upd;
  logic [7:0]       pl [OUT_FIELDS];

  logic             out_valid_r;
  status_t          out_status_r;
  logic [7:0]       out_pl_r [OUT_FIELDS];

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign crc_upd  = crc8_feed(crc_r, in_rx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr1_r <= '0;
      hdr2_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_HEADER_FIRST) begin
        hdr1_r <= cfg_wdata;
      end else if (cfg_index == REG_HEADER_SECOND) begin
        hdr2_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    rem_nxt     = rem_r;
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    last_cr_nxt = last_cr_r;
    emit        = 1'b0;
    emit_status = ST_OK;
    case (phase_r)
      PH_HDR1: begin
        if (in_rx_byte != hdr1_r) begin
          emit        = 1'b1;
          emit_status = ST_HDR;
        end else begin
          crc_nxt   = crc8_feed(8'h00, in_rx_byte);
          phase_nxt = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (in_rx_byte != hdr2_r) begin
          emit        = 1'b1;
          emit_status = ST_HDR;
        end else begin
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        crc_nxt   = crc_upd;
        rem_nxt   = in_rx_byte;
        idx_nxt   = '0;
        phase_nxt = (in_rx_byte == 8'h00) ? PH_CRC : PH_DATA;
      end
      PH_DATA: begin
        crc_nxt = crc_upd;
        // Saturate the index once the capture buffer is full.
        if (idx_r < IDX_W'(CAPTURED_BYTES)) begin
          idx_nxt = idx_r + 1'b1;
        end
        rem_nxt = rem_r - 8'd1;
        if (rem_nxt == 8'h00) begin
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        emit        = 1'b1;
        emit_status = (in_rx_byte != crc_r) ? ST_CRC : ST_OK;
      end
      default: begin
        if (last_cr_r && in_rx_byte == BYTE_LF) begin
          phase_nxt   = PH_HDR1;
          last_cr_nxt = 1'b0;
        end else begin
          phase_nxt   = PH_SKIP;
          last_cr_nxt = (in_rx_byte == BYTE_CR);
        end
      end
    endcase
    if (emit) begin
      phase_nxt   = PH_SKIP;
      last_cr_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR1;
      rem_r     <= '0;
      idx_r     <= '0;
      crc_r     <= '0;
      last_cr_r <= 1'b0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
      idx_r     <= idx_nxt;
      crc_r     <= crc_nxt;
      last_cr_r <= last_cr_nxt;
    end
  end

  // Capture buffer: cleared on the length byte, filled in payload order.
  always_ff @(posedge clk) begin
    if (acc && phase_r == PH_LEN) begin
      for (int i = 0; i < CAPTURED_BYTES; i++) begin
        cap_r[i] <= '0;
      end
    end else if (acc && phase_r == PH_DATA && idx_r < IDX_W'(CAPTURED_BYTES)) begin
      cap_r[idx_r[CAP_AW-1:0]] <= in_rx_byte;
    end
  end

  for (genvar g = 0; g < OUT_FIELDS; g++) begin : g_pl
    if (g < CAPTURED_BYTES) begin : g_cap
      assign pl[g] = cap_r[g];
    end else begin : g_zero
      assign pl[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      out_status_r <= emit_status;
      for (int j = 0; j < OUT_FIELDS; j++) begin
        out_pl_r[j] <= (emit_status == ST_OK) ? pl[j] : 8'h00;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_frame_status     = out_status_r;
  assign out_controller_state = out_pl_r[0];
  assign out_object_state     = out_pl_r[1];
  assign out_color_one        = out_pl_r[2];
  assign out_color_two        = out_pl_r[3];
  assign out_color_three      = out_pl_r[4];

  `SFC_ASSERT_NOW(a_data_has_bytes, phase_r == PH_DATA, rem_r != 8'h00, "payload phase with zero count")
  `SFC_ASSERT_NEXT(a_crc_byte_emits, acc && phase_r == PH_CRC, out_valid_r && phase_r == PH_SKIP, "CRC byte gave no result")
  `SFC_ASSERT_NOW(a_bad_frame_zero, out_valid_r && out_status_r != ST_OK, out_controller_state == 8'h00 && out_color_three == 8'h00, "failed frame carries payload")
  `SFC_ASSERT_NEXT(a_skip_exit, acc && phase_r == PH_SKIP, phase_r == PH_SKIP || phase_r == PH_HDR1, "bad exit from skip phase")

endmodule

>>> test/tb_serial_frame_crc8_receiver_core.sv
// Testbench for the serial frame receiver core: framed byte traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_serial_frame_crc8_receiver_core;
  import sfcrc8_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    status_t                     status;
    logic [0:OUT_FIELDS-1][7:0]  payload;
  } frame_result_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  status_t              out_frame_status;
  logic [7:0]           out_controller_state;
  logic [7:0]           out_object_state;
  logic [7:0]           out_color_one;
  logic [7:0]           out_color_two;
  logic [7:0]           out_color_three;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = 8'h00;

  serial_frame_crc8_receiver_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_frame_status     (out_frame_status),
    .out_controller_state (out_controller_state),
    .out_object_state     (out_object_state),
    .out_color_one        (out_color_one),
    .out_color_two        (out_color_two),
    .out_color_three      (out_color_three),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [7:0]                 hdr_first = 8'h00;
  logic [7:0]                 hdr_second = 8'h00;
  phase_t                     rx_phase = PH_HDR1;
  logic [7:0]                 bytes_left = 8'h00;
  logic [7:0]                 byte_pos = 8'h00;
  logic [7:0]                 frame_crc = 8'h00;
  logic [0:OUT_FIELDS-1][7:0] kept_bytes = '0;
  logic                       saw_cr = 1'b0;

  logic [7:0]    rx_pending[$];
  frame_result_t frames_due[$];
  int            frame_bytes = 0;
  int            mismatches = 0;
  logic          quiet = 1'b0;
  int            send_gap = 0;
  int            hold_left = 0;

  // Reflected CRC-8, bit-serial form: feed data LSB first into the register.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r  = {1'b0, r[7:1]};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    frame_result_t r;
    logic          done;
    r    = '0;
    done = 1'b0;
    case (rx_phase)
      PH_HDR1: begin
        if (b != hdr_first) begin
          done     = 1'b1;
          r.status = ST_HDR;
        end else begin
          frame_crc = crc8_step(8'h00, b);
          rx_phase  = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (b != hdr_second) begin
          done     = 1'b1;
          r.status = ST_HDR;
        end else begin
          frame_crc = crc8_step(frame_crc, b);
          rx_phase  = PH_LEN;
        end
      end
      PH_LEN: begin
        frame_crc  = crc8_step(frame_crc, b);
        kept_bytes = '0;
        bytes_left = b;
        byte_pos   = 8'h00;
        rx_phase   = (b == 8'h00) ? PH_CRC : PH_DATA;
      end
      PH_DATA: begin
        frame_crc = crc8_step(frame_crc, b);
        if (byte_pos < CAPTURED_BYTES_DEF) kept_bytes[byte_pos[2:0]] = b;
        byte_pos   = byte_pos + 8'd1;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) rx_phase = PH_CRC;
      end
      PH_CRC: begin
        done = 1'b1;
        if (b != frame_crc) begin
          r.status = ST_CRC;
        end else begin
          r.status  = ST_OK;
          r.payload = kept_bytes;
        end
      end
      default: begin
        if (saw_cr && b == BYTE_LF) begin
          rx_phase = PH_HDR1;
          saw_cr   = 1'b0;
        end else begin
          saw_cr = (b == BYTE_CR);
        end
      end
    endcase
    // The byte that closes a frame never counts as the CR of the line end.
    if (done) begin
      frames_due.push_back(r);
      rx_phase = PH_SKIP;
      saw_cr   = 1'b0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 149) == 0) quiet <= !quiet;
  end

  // Driver: present one word at a time, hold it until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'h00;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) parse_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_pending.pop_front();
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take result words and compare with the oldest expected frame.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $error("result word with no frame pending: status %0d", out_frame_status);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          check_field("frame_status", {6'b0, want.status}, {6'b0, out_frame_status});
          check_field("controller_state", want.payload[0], out_controller_state);
          check_field("object_state", want.payload[1], out_object_state);
          check_field("color_one", want.payload[2], out_color_one);
          check_field("color_two", want.payload[3], out_color_two);
          check_field("color_three", want.payload[4], out_color_three);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        hold_left = pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HEADER_FIRST:  hdr_first = val;
      REG_HEADER_SECOND: hdr_second = val;
      default: ;
    endcase
  endtask

  task automatic set_headers(input logic [7:0] h1, input logic [7:0] h2);
    write_reg(REG_HEADER_FIRST, h1);
    write_reg(REG_HEADER_SECOND, h2);
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI,
              8'($urandom_range(0, 255)));
  endtask

  // Wait until every word is sent and every frame result is back.
  task automatic settle();
    do @(negedge clk);
    while (rx_pending.size() != 0 || in_valid || frames_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic queue_frame(input logic [7:0] h1, input logic [7:0] h2, input byte_q_t body,
                             input logic [7:0] crc_flip);
    logic [7:0] c;
    logic [7:0] len;
    len = 8'(body.size());
    c = crc8_step(8'h00, h1);
    c = crc8_step(c, h2);
    c = crc8_step(c, len);
    rx_pending.push_back(h1);
    rx_pending.push_back(h2);
    rx_pending.push_back(len);
    foreach (body[i]) begin
      c = crc8_step(c, body[i]);
      rx_pending.push_back(body[i]);
    end
    rx_pending.push_back(c ^ crc_flip);
    frame_bytes += body.size() + 4;
  endtask

  // Optional junk, then CR LF. Junk holds no CR so it cannot end the line early.
  task automatic queue_line_end(input int junk);
    logic [7:0] b;
    repeat (junk) begin
      do b = 8'($urandom_range(0, 255));
      while (b == BYTE_CR);
      rx_pending.push_back(b);
    end
    rx_pending.push_back(BYTE_CR);
    rx_pending.push_back(BYTE_LF);
  endtask

  task automatic random_traffic(input int budget);
    int         target;
    int         pick;
    int         len;
    int         cut;
    logic [7:0] h1;
    logic [7:0] h2;
    logic [7:0] nz;
    logic [7:0] b;
    byte_q_t    body;
    target = frame_bytes + budget;
    while (frame_bytes < target) begin
      pick = $urandom_range(0, 99);
      nz   = 8'($urandom_range(1, 255));
      len  = $urandom_range(0, 99);
      if (len < 85) len = $urandom_range(0, 8);
      else if (len < 98) len = $urandom_range(9, 40);
      else len = ($urandom_range(0, 1) != 0) ? 255 : $urandom_range(41, 254);
      body.delete();
      repeat (len) begin
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) b = ($urandom_range(0, 1) != 0) ? BYTE_CR : BYTE_LF;
        body.push_back(b);
      end
      h1 = hdr_first;
      h2 = hdr_second;
      if (pick >= 80 && pick < 87) begin
        if ($urandom_range(0, 1) != 0) h1 = h1 ^ nz;
        else h2 = h2 ^ nz;
      end
      if (pick < 94) begin
        queue_frame(h1, h2, body, (pick >= 70 && pick < 80) ? nz : 8'h00);
        // Broken frame: drop its tail so the line end lands inside it.
        if (pick >= 87) begin
          cut = $urandom_range(1, body.size() + 3);
          repeat (cut) void'(rx_pending.pop_back());
        end
      end else begin
        repeat ($urandom_range(1, 6)) rx_pending.push_back(8'($urandom_range(0, 255)));
      end
      queue_line_end(($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3));
    end
  endtask

  initial begin : stimulus
    byte_q_t none;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset headers.
    queue_frame(8'h00, 8'h00, '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, BYTE_CR, BYTE_LF}, 8'h00);
    queue_line_end(0);
    rx_pending.push_back(BYTE_CR);
    rx_pending.push_back(BYTE_LF);
    queue_line_end(0);
    queue_frame(8'h00, 8'hFF, none, 8'h00);
    queue_line_end(0);
    queue_frame(8'h00, 8'h00, none, 8'h00);
    queue_line_end(0);
    queue_frame(8'h00, 8'h00, '{8'hAA, 8'h55}, 8'h00);
    queue_line_end(0);
    queue_frame(8'h00, 8'h00, '{8'h33}, 8'hFF);
    queue_line_end(0);
    settle();

    random_traffic(260);
    settle();
    set_headers(8'hFF, 8'hFF);
    random_traffic(260);
    settle();
    set_headers(BYTE_CR, BYTE_LF);
    random_traffic(260);
    settle();
    set_headers(8'h00, 8'hFF);
    random_traffic(260);
    settle();
    set_headers(8'hFF, 8'h00);
    random_traffic(260);
    settle();
    set_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_traffic(260);
    settle();

    repeat (5) @(posedge clk);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("tb_serial_frame_crc8_receiver_core OK");
    end else begin
      $display("tb_serial_frame_crc8_receiver_core NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_serial_frame_crc8_receiver_core NOT OK");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/sfcrc8_pkg.sv
src/serial_frame_crc8_receiver_core.sv
test/tb_serial_frame_crc8_receiver_core.sv
